// ----- hw/rtl/psrq_pkg.sv -----
// Shared types and constants for the policy sorted request queue.
package psrq_pkg;

  localparam int unsigned HandleW = 16;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned OccW    = 5;
  localparam int unsigned PolicyW = 2;

  localparam logic OpEnq = 1'b0;
  localparam logic OpDeq = 1'b1;

  localparam logic [PolicyW-1:0] PolicyFifo    = 2'd0;
  localparam logic [PolicyW-1:0] PolicyLargest = 2'd1;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PtrHold = 3'd0,
    PtrZero = 3'd1,
    PtrFill = 3'd2,
    PtrInc  = 3'd3,
    PtrDec  = 3'd4
  } ptr_op_e;

  typedef enum logic [1:0] {
    RdZero  = 2'd0,
    RdPtr   = 2'd1,
    RdPtrM1 = 2'd2,
    RdPtrP1 = 2'd3
  } rd_sel_e;

  typedef enum logic {
    WrMove = 1'b0,
    WrNew  = 1'b1
  } wr_sel_e;

  typedef struct packed {
    logic    capture;
    ptr_op_e ptr_op;
    logic    pos_ld;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    fill_inc;
    logic    fill_dec;
    logic    head_ld;
  } psrq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic fifo;
    logic at_fill;
    logic at_pos;
    logic at_last;
    logic hit;
  } psrq_stat_t;

endpackage

// ----- hw/rtl/psrq_ctrl.sv -----
// Controller state machine: sequences scan, shift, insert and pop steps.
module psrq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 opcode_i,
  input  psrq_pkg::psrq_stat_t stat_i,
  output psrq_pkg::psrq_cmd_t  cmd_o,
  output logic                 busy,
  output logic                 done_o
);

  typedef enum logic [9:0] {
    SIdle    = 10'b0000000001,
    SScanRd  = 10'b0000000010,
    SScanChk = 10'b0000000100,
    SShiftRd = 10'b0000001000,
    SShiftWr = 10'b0000010000,
    SPut     = 10'b0000100000,
    SPopHead = 10'b0001000000,
    SPopRd   = 10'b0010000000,
    SPopWr   = 10'b0100000000,
    SDone    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    cmd_o.ptr_op = psrq_pkg::PtrHold;
    cmd_o.rd_sel = psrq_pkg::RdZero;
    cmd_o.wr_sel = psrq_pkg::WrMove;
    unique case (state_q)
      SIdle: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          if (opcode_i == psrq_pkg::OpEnq) begin
            if (stat_i.full) begin
              state_d = SDone;
            end else begin
              // arrival order: start the scan already at the tail
              cmd_o.ptr_op = stat_i.fifo ? psrq_pkg::PtrFill : psrq_pkg::PtrZero;
              state_d      = SScanRd;
            end
          end else begin
            if (stat_i.empty) begin
              state_d = SDone;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = psrq_pkg::RdZero;
              state_d      = SPopHead;
            end
          end
        end
      end
      SScanRd: begin
        if (stat_i.at_fill) begin
          cmd_o.pos_ld = 1'b1;
          state_d      = SShiftRd;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = psrq_pkg::RdPtr;
          state_d      = SScanChk;
        end
      end
      SScanChk: begin
        if (stat_i.hit) begin
          cmd_o.pos_ld = 1'b1;
          cmd_o.ptr_op = psrq_pkg::PtrFill;
          state_d      = SShiftRd;
        end else begin
          cmd_o.ptr_op = psrq_pkg::PtrInc;
          state_d      = SScanRd;
        end
      end
      SShiftRd: begin
        if (stat_i.at_pos) begin
          state_d = SPut;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = psrq_pkg::RdPtrM1;
          state_d      = SShiftWr;
        end
      end
      SShiftWr: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = psrq_pkg::WrMove;
        cmd_o.ptr_op = psrq_pkg::PtrDec;
        state_d      = SShiftRd;
      end
      SPut: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = psrq_pkg::WrNew;
        cmd_o.fill_inc = 1'b1;
        state_d        = SDone;
      end
      SPopHead: begin
        cmd_o.head_ld = 1'b1;
        cmd_o.ptr_op  = psrq_pkg::PtrZero;
        state_d       = SPopRd;
      end
      SPopRd: begin
        if (stat_i.at_last) begin
          cmd_o.fill_dec = 1'b1;
          state_d        = SDone;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = psrq_pkg::RdPtrP1;
          state_d      = SPopWr;
        end
      end
      SPopWr: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = psrq_pkg::WrMove;
        cmd_o.ptr_op = psrq_pkg::PtrInc;
        state_d      = SPopRd;
      end
      SDone: begin
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign busy   = (state_q != SIdle);
  assign done_o = (state_q == SDone);

endmodule

// ----- hw/rtl/psrq_dp.sv -----
// Datapath: slot memory, pointers, fill count, policy register and result registers.
module psrq_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  psrq_pkg::psrq_cmd_t                  cmd_i,
  output psrq_pkg::psrq_stat_t                 stat_o,
  input  logic                                 opcode_i,
  input  logic [psrq_pkg::HandleW-1:0]         handle_i,
  input  logic [psrq_pkg::KeyW-1:0]            sort_key_i,
  input  logic                                 cfg_wr_i,
  input  logic [psrq_pkg::PolicyW-1:0]         cfg_data_i,
  output logic [1:0]                           status_o,
  output logic [psrq_pkg::HandleW-1:0]         head_handle_o,
  output logic [psrq_pkg::KeyW-1:0]            head_key_o,
  output logic [psrq_pkg::OccW-1:0]            occupancy_o
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned EntW = psrq_pkg::HandleW + psrq_pkg::KeyW;

  logic [EntW-1:0] mem_q [DEPTH];
  logic [EntW-1:0] rdata_q;

  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] pos_q;
  logic [CW-1:0] fill_q;
  logic [psrq_pkg::PolicyW-1:0] policy_q;

  logic [psrq_pkg::HandleW-1:0] handle_q;
  logic [psrq_pkg::KeyW-1:0]    key_q;
  psrq_pkg::status_e            status_q;
  logic [psrq_pkg::HandleW-1:0] head_handle_q;
  logic [psrq_pkg::KeyW-1:0]    head_key_q;

  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic [EntW-1:0]         wr_data;
  logic [psrq_pkg::KeyW-1:0] stored_key;
  psrq_pkg::status_e       status_new;

  always_comb begin
    case (cmd_i.rd_sel)
      psrq_pkg::RdZero:  rd_addr = '0;
      psrq_pkg::RdPtr:   rd_addr = ptr_q[AW-1:0];
      psrq_pkg::RdPtrM1: rd_addr = AW'(ptr_q - CW'(1));
      psrq_pkg::RdPtrP1: rd_addr = AW'(ptr_q + CW'(1));
      default:           rd_addr = '0;
    endcase
  end

  assign wr_addr = (cmd_i.wr_sel == psrq_pkg::WrNew) ? pos_q[AW-1:0] : ptr_q[AW-1:0];
  assign wr_data = (cmd_i.wr_sel == psrq_pkg::WrNew) ? {handle_q, key_q} : rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    case (cmd_i.ptr_op)
      psrq_pkg::PtrZero: ptr_d = '0;
      psrq_pkg::PtrFill: ptr_d = fill_q;
      psrq_pkg::PtrInc:  ptr_d = ptr_q + CW'(1);
      psrq_pkg::PtrDec:  ptr_d = ptr_q - CW'(1);
      default:           ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    status_new = psrq_pkg::StOk;
    if (opcode_i == psrq_pkg::OpEnq && stat_o.full) begin
      status_new = psrq_pkg::StFull;
    end else if (opcode_i == psrq_pkg::OpDeq && stat_o.empty) begin
      status_new = psrq_pkg::StEmpty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      pos_q    <= '0;
      fill_q   <= '0;
      policy_q <= psrq_pkg::PolicyFifo;
    end else begin
      ptr_q <= ptr_d;
      if (cmd_i.pos_ld) begin
        pos_q <= ptr_q;
      end
      if (cmd_i.fill_inc) begin
        fill_q <= fill_q + CW'(1);
      end else if (cmd_i.fill_dec) begin
        fill_q <= fill_q - CW'(1);
      end
      if (cfg_wr_i) begin
        policy_q <= cfg_data_i;
      end
    end
  end

  // latch the beat and clear the head fields; a pop overwrites them later
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      handle_q      <= handle_i;
      key_q         <= sort_key_i;
      status_q      <= status_new;
      head_handle_q <= '0;
      head_key_q    <= '0;
    end else if (cmd_i.head_ld) begin
      {head_handle_q, head_key_q} <= rdata_q;
    end
  end

  assign stored_key = rdata_q[psrq_pkg::KeyW-1:0];

  assign stat_o.full    = (fill_q == CW'(DEPTH));
  assign stat_o.empty   = (fill_q == '0);
  assign stat_o.fifo    = (policy_q == psrq_pkg::PolicyFifo);
  assign stat_o.at_fill = (ptr_q == fill_q);
  assign stat_o.at_pos  = (ptr_q == pos_q);
  assign stat_o.at_last = ((ptr_q + CW'(1)) == fill_q);
  // larger-first stops at a smaller stored key, otherwise at a larger one
  assign stat_o.hit     = (policy_q == psrq_pkg::PolicyLargest) ? (key_q > stored_key)
                                                                : (stored_key > key_q);

  assign status_o      = status_q;
  assign head_handle_o = head_handle_q;
  assign head_key_o    = head_key_q;
  assign occupancy_o   = psrq_pkg::OccW'(fill_q);

endmodule

// ----- hw/rtl/policy_sorted_request_queue_unit.sv -----
// Top level of the policy sorted request queue.
// A refused beat goes straight to done_o; a dequeue moves each remaining item up one slot;
// an enqueue reads slots until one stops the scan or the scan reaches the tail, then moves
// the later items down one slot and writes the new one (in arrival order no slot is read).
// One beat in flight, the next accepted after done_o drops.
// Results cannot be stalled; reset clears the fill count, the policy (arrival order) and
// the controller, not the slot memory.
module policy_sorted_request_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 opcode_i,
  input  logic [psrq_pkg::HandleW-1:0]         handle_i,
  input  logic [psrq_pkg::KeyW-1:0]            sort_key_i,
  output logic                                 done_o,
  output logic [1:0]                           status_o,
  output logic [psrq_pkg::HandleW-1:0]         head_handle_o,
  output logic [psrq_pkg::KeyW-1:0]            head_key_o,
  output logic [psrq_pkg::OccW-1:0]            occupancy_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [psrq_pkg::PolicyW-1:0]         cfg_data_i
);

  psrq_pkg::psrq_cmd_t  cmd;
  psrq_pkg::psrq_stat_t stat;

  assign cfg_ready_o = 1'b1;

  psrq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  psrq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .opcode_i      (opcode_i),
    .handle_i      (handle_i),
    .sort_key_i    (sort_key_i),
    .cfg_wr_i      (cfg_valid_i & cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .status_o      (status_o),
    .head_handle_o (head_handle_o),
    .head_key_o    (head_key_o),
    .occupancy_o   (occupancy_o)
  );

endmodule

// ----- hw/rtl/psrq_checker.sv -----
// Port-level checker for the policy sorted request queue, bound to the top level.
module psrq_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic [1:0]                   status_o,
  input logic [psrq_pkg::HandleW-1:0] head_handle_o,
  input logic [psrq_pkg::KeyW-1:0]    head_key_o,
  input logic [psrq_pkg::OccW-1:0]    occupancy_o
);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("block stayed busy after its result");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == psrq_pkg::StFull |->
      occupancy_o == psrq_pkg::OccW'(DEPTH) && head_handle_o == '0 && head_key_o == '0)
    else $error("full refusal with wrong fields");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == psrq_pkg::StEmpty |->
      occupancy_o == '0 && head_handle_o == '0 && head_key_o == '0)
    else $error("empty refusal with wrong fields");

endmodule

bind policy_sorted_request_queue_unit psrq_checker #(
  .DEPTH (DEPTH)
) u_psrq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .head_handle_o (head_handle_o),
  .head_key_o    (head_key_o),
  .occupancy_o   (occupancy_o)
);

// ----- sim/tb_policy_sorted_request_queue_unit.sv -----
// Self-checking testbench for the policy sorted request queue: directed table, then random phases.
module tb_policy_sorted_request_queue_unit;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned LATENCY_MAX = 2 * DEPTH + 4;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned PHASE_BEATS = 60;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned NUM_ROWS    = 28;

  typedef struct packed {
    logic [1:0]                   status;
    logic [psrq_pkg::HandleW-1:0] handle;
    logic [psrq_pkg::KeyW-1:0]    key;
    logic [psrq_pkg::OccW-1:0]    occ;
  } queue_result_t;

  // A policy row carries the new policy in the low key bits.
  typedef struct packed {
    logic                         is_cfg;
    logic                         op;
    logic [psrq_pkg::HandleW-1:0] handle;
    logic [psrq_pkg::KeyW-1:0]    key;
    logic                         pinned;
    queue_result_t                want;
  } stim_row_t;

  localparam queue_result_t NO_PIN = '{psrq_pkg::StOk, 16'h0, 32'h0, 5'd0};

  localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
    '{1'b0, psrq_pkg::OpDeq, 16'hA5A5, 32'h5A5A5A5A, 1'b1,
      '{psrq_pkg::StEmpty, 16'h0, 32'h0, 5'd0}},
    '{1'b0, psrq_pkg::OpEnq, 16'hFFFF, 32'hFFFFFFFF, 1'b1,
      '{psrq_pkg::StOk, 16'h0, 32'h0, 5'd1}},
    '{1'b0, psrq_pkg::OpEnq, 16'h0000, 32'h00000000, 1'b1,
      '{psrq_pkg::StOk, 16'h0, 32'h0, 5'd2}},
    '{1'b0, psrq_pkg::OpDeq, 16'h0000, 32'h00000000, 1'b1,
      '{psrq_pkg::StOk, 16'hFFFF, 32'hFFFFFFFF, 5'd1}},
    '{1'b0, psrq_pkg::OpDeq, 16'hFFFF, 32'hFFFFFFFF, 1'b1,
      '{psrq_pkg::StOk, 16'h0, 32'h0, 5'd0}},
    '{1'b1, psrq_pkg::OpEnq, 16'h0000, {30'h0, psrq_pkg::PolicyLargest}, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpEnq, 16'h0001, 32'd5, 1'b1,
      '{psrq_pkg::StOk, 16'h0, 32'h0, 5'd1}},
    '{1'b0, psrq_pkg::OpEnq, 16'h0002, 32'd9, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpEnq, 16'h0003, 32'd5, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpEnq, 16'h0004, 32'd0, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpDeq, 16'h0000, 32'h0, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpDeq, 16'h0000, 32'h0, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpDeq, 16'h0000, 32'h0, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpDeq, 16'h0000, 32'h0, 1'b0, NO_PIN},
    '{1'b1, psrq_pkg::OpEnq, 16'h0000, 32'd2, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpEnq, 16'h0011, 32'd7, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpEnq, 16'h0012, 32'd3, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpEnq, 16'h0013, 32'd7, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpEnq, 16'h0014, 32'hFFFFFFFF, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpDeq, 16'h0000, 32'h0, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpDeq, 16'h0000, 32'h0, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpDeq, 16'h0000, 32'h0, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpDeq, 16'h0000, 32'h0, 1'b0, NO_PIN},
    '{1'b1, psrq_pkg::OpEnq, 16'h0000, 32'd3, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpEnq, 16'h0021, 32'd4, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpEnq, 16'h0022, 32'd1, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpDeq, 16'h0000, 32'h0, 1'b0, NO_PIN},
    '{1'b0, psrq_pkg::OpDeq, 16'h0000, 32'h0, 1'b0, NO_PIN}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic                         opcode_i;
  logic [psrq_pkg::HandleW-1:0] handle_i;
  logic [psrq_pkg::KeyW-1:0]    sort_key_i;
  logic                         done_o;
  logic [1:0]                   status_o;
  logic [psrq_pkg::HandleW-1:0] head_handle_o;
  logic [psrq_pkg::KeyW-1:0]    head_key_o;
  logic [psrq_pkg::OccW-1:0]    occupancy_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [psrq_pkg::PolicyW-1:0] cfg_data_i;

  // Shadow of the queue contents and policy.
  logic [psrq_pkg::HandleW-1:0] shadow_handles [DEPTH];
  logic [psrq_pkg::KeyW-1:0]    shadow_keys    [DEPTH];
  int unsigned                  shadow_fill = 0;
  logic [psrq_pkg::PolicyW-1:0] shadow_policy = psrq_pkg::PolicyFifo;

  queue_result_t      pending_results [$];
  logic               pin_valid;
  queue_result_t      pin_want;

  int unsigned        mismatches = 0;
  int unsigned        stall_cycles = 0;
  int unsigned        enq_done = 0;
  int unsigned        deq_done = 0;
  int unsigned        full_refused = 0;
  int unsigned        empty_refused = 0;
  int unsigned        peak_fill = 0;
  logic [3:0]         policies_written = '0;

  policy_sorted_request_queue_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .handle_i     (handle_i),
    .sort_key_i   (sort_key_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .head_handle_o(head_handle_o),
    .head_key_o   (head_key_o),
    .occupancy_o  (occupancy_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Apply one beat to the shadow queue and return what the block should report.
  function automatic queue_result_t apply_queue_op(logic op,
                                                   logic [psrq_pkg::HandleW-1:0] hdl,
                                                   logic [psrq_pkg::KeyW-1:0] key);
    queue_result_t res;
    int unsigned   pos;
    res = '{psrq_pkg::StOk, '0, '0, '0};
    if (op == psrq_pkg::OpEnq) begin
      if (shadow_fill >= DEPTH) begin
        res.status = psrq_pkg::StFull;
      end else begin
        pos = 0;
        if (shadow_policy == psrq_pkg::PolicyFifo) begin
          pos = shadow_fill;
        end else begin
          // Ties fall through, so equal keys keep arrival order.
          while (pos < shadow_fill &&
                 !((shadow_policy == psrq_pkg::PolicyLargest) ? (key > shadow_keys[pos])
                                                              : (shadow_keys[pos] > key)))
          begin
            pos++;
          end
        end
        for (int i = shadow_fill; i > pos; i--) begin
          shadow_handles[i] = shadow_handles[i-1];
          shadow_keys[i]    = shadow_keys[i-1];
        end
        shadow_handles[pos] = hdl;
        shadow_keys[pos]    = key;
        shadow_fill++;
      end
    end else begin
      if (shadow_fill == 0) begin
        res.status = psrq_pkg::StEmpty;
      end else begin
        res.handle = shadow_handles[0];
        res.key    = shadow_keys[0];
        for (int i = 0; i + 1 < shadow_fill; i++) begin
          shadow_handles[i] = shadow_handles[i+1];
          shadow_keys[i]    = shadow_keys[i+1];
        end
        shadow_fill--;
      end
    end
    res.occ = shadow_fill[psrq_pkg::OccW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, queue_result_t want, queue_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s: exp status %0d handle %h key %h occ %0d", $realtime, what,
               want.status, want.handle, want.key, want.occ);
      $display("%0t: %s: got status %0d handle %h key %h occ %0d", $realtime, what,
               got.status, got.handle, got.key, got.occ);
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    queue_result_t want;
    queue_result_t got;
    logic          moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        shadow_policy = cfg_data_i;
        policies_written[cfg_data_i] = 1'b1;
        moved = 1'b1;
      end
      if (start && !busy) begin
        want = apply_queue_op(opcode_i, handle_i, sort_key_i);
        if (pin_valid) begin
          want = pin_want;
        end
        pending_results.push_back(want);
        case (want.status)
          psrq_pkg::StFull:  full_refused++;
          psrq_pkg::StEmpty: empty_refused++;
          default: if (opcode_i == psrq_pkg::OpEnq) enq_done++; else deq_done++;
        endcase
        if (shadow_fill > peak_fill) begin
          peak_fill = shadow_fill;
        end
        moved = 1'b1;
      end
      if (done_o) begin
        got = '{status_o, head_handle_o, head_key_o, occupancy_o};
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", NO_PIN, got);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.handle !== want.handle ||
              got.key !== want.key || got.occ !== want.occ) begin
            report_mismatch("result mismatch", want, got);
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic send_beat(logic op, logic [psrq_pkg::HandleW-1:0] hdl,
                           logic [psrq_pkg::KeyW-1:0] key,
                           logic pinned, queue_result_t want);
    start      <= 1'b1;
    opcode_i   <= op;
    handle_i   <= hdl;
    sort_key_i <= key;
    pin_valid  <= pinned;
    pin_want   <= want;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic hold_off(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drain every outstanding beat, then write the policy.
  task automatic write_policy(logic [psrq_pkg::PolicyW-1:0] pol);
    hold_off(1);
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= pol;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [psrq_pkg::KeyW-1:0] pick_key();
    case ($urandom_range(0, 3))
      0:       return psrq_pkg::KeyW'($urandom_range(0, 7));
      1:       return psrq_pkg::KeyW'($urandom());
      2:       return $urandom_range(0, 1) ? '1 : '0;
      default: return psrq_pkg::KeyW'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned enq_pct;
    int unsigned burst_left;
    logic        no_gaps;
    rst_ni      = 1'b0;
    start       = 1'b0;
    opcode_i    = psrq_pkg::OpEnq;
    handle_i    = '0;
    sort_key_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = psrq_pkg::PolicyFifo;
    pin_valid   = 1'b0;
    pin_want    = NO_PIN;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].is_cfg) begin
        write_policy(DIR_ROWS[r].key[psrq_pkg::PolicyW-1:0]);
      end else begin
        send_beat(DIR_ROWS[r].op, DIR_ROWS[r].handle, DIR_ROWS[r].key,
                  DIR_ROWS[r].pinned, DIR_ROWS[r].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_policy(psrq_pkg::PolicyW'($urandom_range(0, 3)));
      case ($urandom_range(0, 2))
        0:       enq_pct = 25;
        1:       enq_pct = 50;
        default: enq_pct = 85;
      endcase
      no_gaps    = (ph % 3 == 0);
      burst_left = $urandom_range(1, 8);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_beat(($urandom_range(0, 99) < enq_pct) ? psrq_pkg::OpEnq : psrq_pkg::OpDeq,
                  psrq_pkg::HandleW'($urandom()), pick_key(), 1'b0, NO_PIN);
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          if (!no_gaps) begin
            hold_off($urandom_range(1, 12));
          end
        end
      end
    end

    hold_off(1);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY_MAX) @(posedge clk_i);

    $display("tb: %0d enqueued, %0d dequeued, %0d refused as full, %0d refused as empty",
             enq_done, deq_done, full_refused, empty_refused);
    $display("tb: peak fill %0d of %0d, policy codes written %b, %0d mismatches",
             peak_fill, DEPTH, policies_written, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
